// ----- rtl/bba_pkg.sv -----
// Package for the first-fit bitmap block allocator.
// Holds map geometry constants, the shared types and the mask helpers.
// No dependencies.
package bba_pkg;

  localparam int unsigned NUM_BLOCKS    = 1024;
  localparam int unsigned MAP_WORD_BITS = 32;
  localparam int unsigned MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned BLK_W         = 10;
  localparam int unsigned BIT_IDX_W     = $clog2(MAP_WORD_BITS);
  localparam int unsigned WORD_IDX_W    = $clog2(MAP_WORDS);
  // Number of real blocks held by the last map word.
  localparam int unsigned LAST_BITS     = NUM_BLOCKS - (MAP_WORDS - 1) * MAP_WORD_BITS;

  typedef logic [BLK_W-1:0]         blk_t;
  typedef logic [MAP_WORD_BITS-1:0] word_t;
  typedef logic [WORD_IDX_W-1:0]    widx_t;
  typedef logic [BIT_IDX_W-1:0]     bidx_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FREE
  } state_e;

  // Controls for the free-bit search on one map word.
  typedef struct packed {
    logic  apply_start;
    logic  is_last;
    bidx_t start_bit;
  } find_ctl_t;

  typedef struct packed {
    logic  hit;
    bidx_t idx;
  } find_res_t;

  // Bits of the last word that lie past the end of the device read as used.
  function automatic word_t tail_mask();
    word_t m;
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      m[i] = (i >= LAST_BITS);
    end
    return m;
  endfunction

  function automatic word_t bit_onehot(bidx_t b);
    word_t m;
    m = '0;
    m[b] = 1'b1;
    return m;
  endfunction

endpackage

// ----- rtl/bba_req_if.sv -----
// Request channel of the bitmap block allocator: valid/ready plus one item.
// Depends on bba_pkg.
interface bba_req_if;
  import bba_pkg::*;

  logic valid;
  logic ready;
  logic cmd;
  blk_t block_number;

  modport source (output valid, output cmd, output block_number, input ready);
  modport sink   (input valid, input cmd, input block_number, output ready);
endinterface

// ----- rtl/bba_rsp_if.sv -----
// Response channel of the bitmap block allocator: valid/ready plus one result item.
// Depends on bba_pkg.
interface bba_rsp_if;
  import bba_pkg::*;

  logic valid;
  logic ready;
  blk_t granted_block;
  logic found;

  modport source (output valid, output granted_block, output found, input ready);
  modport sink   (input valid, input granted_block, input found, output ready);
endinterface

// ----- rtl/bba_find_free.sv -----
// Lowest-free-bit search over one map word, with start and end-of-device masking.
// Depends on bba_pkg.
module bba_find_free (
  input  bba_pkg::word_t     used_word_i,
  input  bba_pkg::find_ctl_t ctl_i,
  output bba_pkg::find_res_t res_o
);
  import bba_pkg::*;

  word_t below_mask;
  word_t blocked;

  always_comb begin
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      below_mask[i] = ctl_i.apply_start && (BIT_IDX_W'(i) < ctl_i.start_bit);
    end
    blocked = used_word_i | below_mask | (ctl_i.is_last ? tail_mask() : '0);
  end

  // Priority encoder: the lowest clear bit wins.
  always_comb begin
    res_o.hit = 1'b0;
    res_o.idx = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!blocked[i]) begin
        res_o.hit = 1'b1;
        res_o.idx = BIT_IDX_W'(i);
      end
    end
  end

endmodule

// ----- rtl/bitmap_block_allocator_unit.sv -----
// A free reads the map word, then clears the bit and loads the output register; an
// allocate scans the map from the word that holds first_data_block, reading one map
// word per cycle until a free bit turns up or the map ends. One item is in flight at a
// time; the output register lets the next item be accepted while a result waits.
// Reset clears the per-word valid flags, so the whole map reads free at once,
// and sets first_data_block to 1.
module bitmap_block_allocator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  bba_pkg::blk_t cfg_data_i,
  bba_req_if.sink       req_i,
  bba_rsp_if.source     rsp_o
);
  import bba_pkg::*;

  // Configuration register: the lowest block an allocation may hand out.
  blk_t fdb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdb_q <= BLK_W'(1);
    end else if (cfg_we_i) begin
      fdb_q <= cfg_data_i;
    end
  end

  // The used map lives in a one-port-read, one-port-write memory with a
  // registered read. A word whose valid flag is clear has never been written
  // since reset and reads as all free.
  word_t                map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] map_vld_q;
  word_t                rd_data_q;
  logic                 rd_vld_q;
  logic                 rd_en;
  widx_t                rd_addr;
  logic                 wr_en;
  widx_t                wr_addr;
  word_t                wr_data;
  word_t                rd_word;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= map_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        map_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= map_vld_q[rd_addr];
      end
    end
  end

  assign rd_word = rd_vld_q ? rd_data_q : '0;

  // Sequencer state. cur_w_q is the word whose data sits in the read register.
  // bad_q marks a request that can never succeed (start or block past the map).
  state_e state_q, state_d;
  widx_t  cur_w_q, cur_w_d;
  logic   first_q, first_d;
  logic   bad_q,   bad_d;
  bidx_t  bit_q,   bit_d;

  // Output register.
  logic   rsp_vld_q;
  blk_t   granted_q;
  logic   found_q;
  logic   rsp_load;
  blk_t   rsp_granted;
  logic   rsp_found;
  logic   out_free;

  logic      req_fire;
  logic      is_last;
  find_ctl_t find_ctl;
  find_res_t find_res;
  logic      blk_in_range;
  logic      fdb_in_range;

  assign out_free     = !rsp_vld_q || rsp_o.ready;
  assign req_fire     = req_i.valid && req_i.ready;
  assign is_last      = (cur_w_q == widx_t'(MAP_WORDS - 1));
  assign blk_in_range = ({1'b0, req_i.block_number} < (BLK_W + 1)'(NUM_BLOCKS));
  assign fdb_in_range = ({1'b0, fdb_q} < (BLK_W + 1)'(NUM_BLOCKS));

  assign find_ctl.apply_start = first_q;
  assign find_ctl.is_last     = is_last;
  assign find_ctl.start_bit   = bidx_t'(fdb_q);

  bba_find_free u_find (
    .used_word_i (rd_word),
    .ctl_i       (find_ctl),
    .res_o       (find_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_w_q <= '0;
      first_q <= 1'b0;
      bad_q   <= 1'b0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_w_q <= cur_w_d;
      first_q <= first_d;
      bad_q   <= bad_d;
      bit_q   <= bit_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_w_d     = cur_w_q;
    first_d     = first_q;
    bad_d       = bad_q;
    bit_d       = bit_q;
    rd_en       = 1'b0;
    rd_addr     = cur_w_q;
    wr_en       = 1'b0;
    wr_addr     = cur_w_q;
    wr_data     = rd_word;
    rsp_load    = 1'b0;
    rsp_granted = '0;
    rsp_found   = 1'b0;
    req_i.ready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          rd_en = 1'b1;
          if (req_i.cmd == CMD_FREE) begin
            rd_addr = widx_t'(req_i.block_number >> BIT_IDX_W);
            cur_w_d = rd_addr;
            bit_d   = bidx_t'(req_i.block_number);
            bad_d   = !blk_in_range;
            state_d = S_FREE;
          end else begin
            rd_addr = widx_t'(fdb_q >> BIT_IDX_W);
            cur_w_d = rd_addr;
            first_d = 1'b1;
            bad_d   = !fdb_in_range;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (bad_q || (!find_res.hit && is_last)) begin
          // Nothing free from the start block to the end of the map.
          if (out_free) begin
            rsp_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else if (find_res.hit) begin
          // Hold the read register until the result slot opens.
          if (out_free) begin
            wr_en       = 1'b1;
            wr_data     = rd_word | bit_onehot(find_res.idx);
            rsp_load    = 1'b1;
            rsp_granted = BLK_W'({cur_w_q, find_res.idx});
            rsp_found   = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          // Word full: fetch the next one, data arrives next cycle.
          rd_en   = 1'b1;
          rd_addr = cur_w_q + widx_t'(1);
          cur_w_d = rd_addr;
          first_d = 1'b0;
        end
      end

      S_FREE: begin
        if (out_free) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
          if (!bad_q && rd_word[bit_q]) begin
            wr_en     = 1'b1;
            wr_data   = rd_word & ~bit_onehot(bit_q);
            rsp_found = 1'b1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      granted_q <= rsp_granted;
      found_q   <= rsp_found;
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.granted_block = granted_q;
  assign rsp_o.found         = found_q;

  // A map write only happens as the closing step of an item.
  a_write_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (rsp_load && rsp_found))
    else $error("map written without a successful result");

  // A result never overwrites one that is still waiting.
  a_no_rsp_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_load |-> (!rsp_vld_q || rsp_o.ready))
    else $error("result register overrun");

  // An accepted item always starts a map access.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == S_SCAN || state_q == S_FREE))
    else $error("accepted item did not start");

  // A granted block never lies below the first data block.
  a_grant_above_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_load && state_q == S_SCAN && rsp_found) |-> (rsp_granted >= fdb_q))
    else $error("granted block below first data block");

  // A free that succeeds leaves the freed bit clear in the written word.
  a_free_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q == S_FREE) |-> !wr_data[bit_q])
    else $error("freed bit still set");

endmodule
